// ===== rtl/aph_pkg.sv =====
// shared constants, types and functions of the adler-32 bucket hash
package aph_pkg;

    localparam int unsigned ADLER_MOD   = 65521;
    localparam int unsigned MAX_BUCKETS = 30;
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned CHK_W       = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned BKT_W       = 5;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned DIV_CNT_W   = $clog2(CHK_W);

    localparam logic [CFG_IDX_W-1:0] CFG_SEED    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS = CFG_IDX_W'(1);

    typedef struct packed {
        logic             valid;
        logic [CHK_W-1:0] checksum;
    } t_q_push;

    typedef struct packed {
        logic             empty;
        logic [CHK_W-1:0] checksum;
    } t_q_head;

    function automatic logic [SUM_W-1:0] fold_seed(input logic [SUM_W-1:0] half);
        logic [SUM_W-1:0] res;
        if (half >= SUM_W'(ADLER_MOD)) begin
            res = half - SUM_W'(ADLER_MOD);
        end else begin
            res = half;
        end
        return res;
    endfunction

    function automatic logic [BKT_W-1:0] eff_buckets(input logic [BKT_W-1:0] n);
        logic [BKT_W-1:0] res;
        if (n == '0) begin
            res = BKT_W'(1);
        end else if (n > BKT_W'(MAX_BUCKETS)) begin
            res = BKT_W'(MAX_BUCKETS);
        end else begin
            res = n;
        end
        return res;
    endfunction

endpackage

// ===== rtl/aph_ifs.sv =====
// item channels and configuration write channel
interface aph_byte_if import aph_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface aph_result_if import aph_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CHK_W-1:0] checksum;
    logic [BKT_W-1:0] bucket;
    modport source (output valid, output checksum, output bucket, input ready);
    modport sink (input valid, input checksum, input bucket, output ready);
endinterface

interface aph_cfg_if import aph_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CHK_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/aph_front.sv =====
// byte intake: running adler-32 sums, pushes the checksum on the last byte
module aph_front import aph_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    aph_byte_if.sink         i_byte,
    input  logic             i_q_full,
    input  logic             i_seed_load,
    input  logic [CHK_W-1:0] i_seed,
    output t_q_push          o_push
);

    logic [SUM_W-1:0] r_lo, n_lo;
    logic [SUM_W-1:0] r_hi, n_hi;
    logic [SUM_W:0]   lo_sum;
    logic [SUM_W:0]   hi_sum;
    logic [SUM_W-1:0] lo_step;
    logic [SUM_W-1:0] hi_step;
    logic             take;

    assign i_byte.ready = !i_q_full;
    assign take = i_byte.valid && i_byte.ready;

    always_comb begin
        lo_sum = {1'b0, r_lo} + (SUM_W+1)'(i_byte.data_byte);
        if (lo_sum >= (SUM_W+1)'(ADLER_MOD)) begin
            lo_step = SUM_W'(lo_sum - (SUM_W+1)'(ADLER_MOD));
        end else begin
            lo_step = lo_sum[SUM_W-1:0];
        end
        hi_sum = {1'b0, r_hi} + {1'b0, lo_step};
        if (hi_sum >= (SUM_W+1)'(ADLER_MOD)) begin
            hi_step = SUM_W'(hi_sum - (SUM_W+1)'(ADLER_MOD));
        end else begin
            hi_step = hi_sum[SUM_W-1:0];
        end
    end

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        o_push.valid    = take && i_byte.last_byte;
        o_push.checksum = {hi_step, lo_step};
        priority if (i_seed_load) begin
            n_lo = fold_seed(i_seed[SUM_W-1:0]);
            n_hi = fold_seed(i_seed[CHK_W-1:SUM_W]);
        end else if (take && i_byte.last_byte) begin
            n_lo = fold_seed(i_seed[SUM_W-1:0]);
            n_hi = fold_seed(i_seed[CHK_W-1:SUM_W]);
        end else if (take) begin
            n_lo = lo_step;
            n_hi = hi_step;
        end else begin
            n_lo = r_lo;
            n_hi = r_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

endmodule

// ===== rtl/aph_queue.sv =====
// short checksum queue between intake and bucket divider
module aph_queue import aph_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_push,
    input  logic    i_pop,
    output logic    o_full,
    output t_q_head o_head
);

    logic [CHK_W-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full          = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_head.empty    = (r_cnt == '0);
    assign o_head.checksum = r_mem[r_rp];
    assign do_push         = i_push.valid && !o_full;
    assign do_pop          = i_pop && !o_head.empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + QCNT_W'(1);
            2'b01:   n_cnt = r_cnt - QCNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.checksum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/aph_back.sv =====
// bit-serial checksum modulo bucket count, with output register
module aph_back import aph_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_head          i_head,
    input  logic [BKT_W-1:0] i_buckets,
    output logic             o_pop,
    aph_result_if.source     o_result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [CHK_W-1:0]     r_div, n_div;
    logic [CHK_W-1:0]     r_sum, n_sum;
    logic [BKT_W-1:0]     r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [CHK_W-1:0]     r_out_sum, n_out_sum;
    logic [BKT_W-1:0]     r_out_bkt, n_out_bkt;
    logic [BKT_W:0]       trial;
    logic [BKT_W-1:0]     rem_step;
    logic                 out_free;
    logic                 last_step;

    assign o_result.valid    = r_out_valid;
    assign o_result.checksum = r_out_sum;
    assign o_result.bucket   = r_out_bkt;

    assign out_free  = !r_out_valid || o_result.ready;
    assign last_step = (r_cnt == DIV_CNT_W'(CHK_W - 1));
    assign o_pop     = (r_state == S_IDLE) && !i_head.empty;

    always_comb begin
        trial = {r_rem, r_div[CHK_W-1]};
        if (trial >= {1'b0, i_buckets}) begin
            rem_step = BKT_W'(trial - {1'b0, i_buckets});
        end else begin
            rem_step = trial[BKT_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_div       = r_div;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_sum   = r_out_sum;
        n_out_bkt   = r_out_bkt;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_div   = i_head.checksum;
                    n_sum   = i_head.checksum;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!last_step) begin
                    n_rem = rem_step;
                    n_div = {r_div[CHK_W-2:0], 1'b0};
                    n_cnt = r_cnt + DIV_CNT_W'(1);
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_sum;
                    n_out_bkt   = rem_step;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_div     <= n_div;
        r_sum     <= n_sum;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_out_sum <= n_out_sum;
        r_out_bkt <= n_out_bkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_rem_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < i_buckets))
        else $error("partial remainder not below bucket count");

    a_bucket_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_bkt < i_buckets))
        else $error("bucket not below bucket count");

    a_result_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) |-> $past(r_state == S_DIV)))
        else $error("result appeared without a finished division");

    a_pop_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_DIV && r_cnt == '0))
        else $error("queue pop did not start a division");

endmodule

// ===== rtl/adler32_path_bucket_hash_unit.sv =====
// top level of the adler-32 name hash with bucket selection
// Bytes of a name enter on i_byte at one per cycle while the queue has room; the front
// keeps both adler-32 sums (mod 65521) and, on the byte flagged last, hands the 32-bit
// checksum to a two-entry queue and reloads the sums from the seed. The back reduces each
// checksum modulo the bucket count with a bit-serial divider, one checksum bit per cycle,
// holding the last bit until its output register is free, and takes the next checksum
// from the queue only when it is idle; intake stalls while the queue is full.
// Register 0 is the seed (low half seeds the first sum, high half the second) and reloads
// the sums when written; register 1 is the bucket count, where zero acts as one and
// values above 30 act as 30.
module adler32_path_bucket_hash_unit import aph_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    aph_byte_if.sink     i_byte,
    aph_cfg_if.sink      i_cfg,
    aph_result_if.source o_result
);

    logic [CHK_W-1:0] r_seed;
    logic [BKT_W-1:0] r_bkt;
    logic             cfg_take;
    logic             seed_load;
    t_q_push          q_push;
    t_q_head          q_head;
    logic             q_full;
    logic             q_pop;

    assign i_cfg.ready = 1'b1;
    assign cfg_take    = i_cfg.valid && i_cfg.ready;
    assign seed_load   = cfg_take && (i_cfg.index == CFG_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_bkt  <= BKT_W'(1);
        end else if (cfg_take) begin
            if (i_cfg.index == CFG_SEED) begin
                r_seed <= i_cfg.data;
            end
            if (i_cfg.index == CFG_BUCKETS) begin
                r_bkt <= i_cfg.data[BKT_W-1:0];
            end
        end
    end

    aph_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .i_q_full    (q_full),
        .i_seed_load (seed_load),
        .i_seed      (seed_load ? i_cfg.data : r_seed),
        .o_push      (q_push)
    );

    aph_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    aph_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_buckets (eff_buckets(r_bkt)),
        .o_pop     (q_pop),
        .o_result  (o_result)
    );

endmodule

// ===== sim/tb_top.sv =====
// testbench for the adler-32 name hash: directed and random names checked against a local model
module tb_top;
    import aph_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_BYTES = 1600;
    localparam int unsigned PHASE_BYTES  = 200;

    typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

    typedef struct {
        logic [CHK_W-1:0] checksum;
        logic [BKT_W-1:0] bucket;
    } name_hash_t;

    class name_hash_tracker;
        logic [CHK_W-1:0] seed;
        logic [BKT_W-1:0] buckets;
        logic [SUM_W-1:0] sum_lo;
        logic [SUM_W-1:0] sum_hi;
        name_hash_t       pending_hashes[$];
        int unsigned      errors;

        function new();
            seed    = '0;
            buckets = BKT_W'(1);
            errors  = 0;
            reload();
        endfunction

        function logic [SUM_W-1:0] add_mod(input logic [SUM_W-1:0] a, input logic [SUM_W-1:0] b);
            int unsigned t;
            t = 32'(a) + 32'(b);
            if (t >= ADLER_MOD) begin
                t -= ADLER_MOD;
            end
            return SUM_W'(t);
        endfunction

        function void reload();
            sum_lo = add_mod(seed[SUM_W-1:0], '0);
            sum_hi = add_mod(seed[CHK_W-1:SUM_W], '0);
        endfunction

        function void note_write(input logic [CFG_IDX_W-1:0] idx, input logic [CHK_W-1:0] val);
            if (idx == CFG_SEED) begin
                seed = val;
                reload();
            end else if (idx == CFG_BUCKETS) begin
                buckets = val[BKT_W-1:0];
            end
        endfunction

        function void note_byte(input logic [BYTE_W-1:0] b, input logic last);
            int unsigned n;
            name_hash_t  h;
            sum_lo = add_mod(sum_lo, SUM_W'(b));
            sum_hi = add_mod(sum_hi, sum_lo);
            if (last) begin
                n = 32'(buckets);
                if (n == 0) begin
                    n = 1;
                end else if (n > MAX_BUCKETS) begin
                    n = MAX_BUCKETS;
                end
                h.checksum = {sum_hi, sum_lo};
                h.bucket   = BKT_W'(h.checksum % n);
                pending_hashes.push_back(h);
                reload();
            end
        endfunction

        task report(input string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_result(input logic [CHK_W-1:0] chk, input logic [BKT_W-1:0] bkt);
            name_hash_t h;
            if (pending_hashes.size() == 0) begin
                report($sformatf("unexpected result checksum %h bucket %0d", chk, bkt));
                return;
            end
            h = pending_hashes.pop_front();
            if (chk !== h.checksum) begin
                report($sformatf("checksum %h, expected %h", chk, h.checksum));
            end
            if (bkt !== h.bucket) begin
                report($sformatf("bucket %0d, expected %0d (checksum %h)", bkt, h.bucket,
                                 h.checksum));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    aph_byte_if   byte_if();
    aph_cfg_if    cfg_if();
    aph_result_if res_if();

    adler32_path_bucket_hash_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    name_hash_tracker tracker = new();
    int unsigned      burst_left = 0;
    bit               gaps_on = 1'b1;
    int unsigned      cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            tracker.check_result(res_if.checksum, res_if.bucket);
        end
    end

    // receiver stalls in runs of random mode and length
    initial begin
        int unsigned run_left;
        rx_mode_t    mode;
        res_if.ready = 1'b0;
        run_left     = 0;
        mode         = RX_OPEN;
        forever begin
            @(posedge i_clk);
            if (run_left == 0) begin
                run_left = $urandom_range(16, 160);
                mode     = rx_mode_t'($urandom_range(0, 2));
            end
            run_left--;
            case (mode)
                RX_OPEN: res_if.ready <= 1'b1;
                RX_COIN: res_if.ready <= 1'($urandom_range(0, 1));
                default: res_if.ready <= ($urandom_range(0, 11) == 0);
            endcase
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap != 0) begin
                byte_if.valid     <= 1'b0;
                byte_if.data_byte <= BYTE_W'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.last_byte <= last;
        do @(posedge i_clk); while (!byte_if.ready);
        tracker.note_byte(b, last);
    endtask

    task automatic send_run(input logic [BYTE_W-1:0] b, input int unsigned n, input logic ends);
        for (int unsigned k = 0; k < n; k++) begin
            send_byte(b, ends && (k == n - 1));
        end
    endtask

    // drain all results, then give the divider time to finish
    task automatic settle();
        byte_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (tracker.pending_hashes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // leaves valid high so back-to-back writes need no lowering
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHK_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        tracker.note_write(idx, val);
    endtask

    function automatic logic [CHK_W-1:0] bucket_word(input logic [BKT_W-1:0] n);
        logic [CHK_W-1:0] w;
        w             = $urandom;
        w[BKT_W-1:0] = n;
        return w;
    endfunction

    task automatic random_config();
        logic [CHK_W-1:0] s;
        logic [BKT_W-1:0] n;
        bit               seed_first;
        case ($urandom_range(0, 6))
            0: s = '0;
            1: s = '1;
            2: s = {SUM_W'(ADLER_MOD - 1), SUM_W'(ADLER_MOD)};
            3: s = {SUM_W'(ADLER_MOD), SUM_W'($urandom)};
            default: s = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0: n = '0;
            1: n = '1;
            2: n = BKT_W'(MAX_BUCKETS);
            default: n = BKT_W'($urandom_range(1, 31));
        endcase
        seed_first = 1'($urandom_range(0, 1));
        if (seed_first && $urandom_range(0, 3) != 0) begin
            write_reg(CFG_SEED, s);
        end
        write_reg(CFG_BUCKETS, bucket_word(n));
        if (!seed_first && $urandom_range(0, 3) != 0) begin
            write_reg(CFG_SEED, s);
        end
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(int'(CFG_BUCKETS) + 1, (1 << CFG_IDX_W) - 1)),
                      $urandom);
        end
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 14) begin
            return $urandom_range(1, 6);
        end else if (r < 19) begin
            return $urandom_range(7, 40);
        end
        return $urandom_range(41, 120);
    endfunction

    initial begin
        int unsigned sent;
        int unsigned phase_sent;
        int unsigned len;
        i_rst_n           = 1'b0;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = '0;
        byte_if.last_byte = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        sent              = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: zero seed, one bucket
        send_run(8'h00, 1, 1'b1);
        send_run(8'hff, 1, 1'b1);

        // seed halves above the modulus, bucket count saturating
        settle();
        write_reg(CFG_SEED, '1);
        write_reg(CFG_BUCKETS, bucket_word('1));
        cfg_if.valid <= 1'b0;
        send_run(8'hff, 4, 1'b1);

        // seed just below the modulus, zero buckets
        settle();
        write_reg(CFG_SEED, {SUM_W'(ADLER_MOD - 1), SUM_W'(ADLER_MOD - 1)});
        write_reg(CFG_BUCKETS, bucket_word('0));
        cfg_if.valid <= 1'b0;
        send_run(8'h01, 1, 1'b1);
        send_run(8'hff, 2, 1'b1);

        // seed rewritten while a name is open drops its bytes
        settle();
        write_reg(CFG_SEED, {SUM_W'(ADLER_MOD), SUM_W'(0)});
        write_reg(CFG_BUCKETS, bucket_word(BKT_W'(MAX_BUCKETS)));
        cfg_if.valid <= 1'b0;
        send_run(8'haa, 2, 1'b0);
        settle();
        write_reg(CFG_SEED, {SUM_W'(0), SUM_W'(ADLER_MOD)});
        cfg_if.valid <= 1'b0;
        send_run(8'h80, 1, 1'b1);

        // unused register indexes are ignored
        settle();
        write_reg(CFG_BUCKETS, bucket_word(BKT_W'(7)));
        write_reg(CFG_BUCKETS + CFG_IDX_W'(1), '1);
        write_reg('1, $urandom);
        cfg_if.valid <= 1'b0;
        send_run(8'h7f, 1, 1'b0);
        send_run(8'hfe, 1, 1'b1);

        settle();
        write_reg(CFG_BUCKETS, bucket_word(BKT_W'(1)));
        cfg_if.valid <= 1'b0;
        send_run(8'h00, 3, 1'b1);
        send_run(8'h55, 5, 1'b1);

        for (int unsigned p = 0; sent < RANDOM_BYTES; p++) begin
            settle();
            random_config();
            gaps_on    = (p % 3) != 2;
            phase_sent = 0;
            while (phase_sent < PHASE_BYTES) begin
                len = pick_length();
                for (int unsigned k = 0; k < len; k++) begin
                    send_byte(pick_byte(), k == len - 1);
                end
                phase_sent += len;
            end
            // sometimes leave a name open across the next register writes
            if ($urandom_range(0, 1) == 1) begin
                len = $urandom_range(1, 5);
                for (int unsigned k = 0; k < len; k++) begin
                    send_byte(pick_byte(), 1'b0);
                end
                phase_sent += len;
            end
            sent += phase_sent;
        end

        settle();
        if (tracker.errors == 0 && tracker.pending_hashes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
